@@ rtl/bmo_pkg.sv @@
// shared types and constants for the 3x3 binary morphology block
package bmo_pkg;

  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int ROW_W      = 13;
  localparam int MIN_SIZE   = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
  localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;

  // request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // spread modes
  localparam logic MODE_SPREAD_HIGH = 1'b0;
  localparam logic MODE_SPREAD_LOW  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SPREAD_MODE  = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic               spread_mode;
  } cfg_t;

  // one request on its way through the window stage
  typedef struct packed {
    logic has;
    logic last;
    logic c_zero;
    logic c_one;
    logic top_ok;
    logic bot_ok;
    logic mode;
    pix_t pixel;
  } item_t;

endpackage

@@ rtl/bmo_pix_in_if.sv @@
// input pixel channel
interface bmo_pix_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_in;

  modport source(output valid, output req_type, output pixel_in, input ready);
  modport sink(input valid, input req_type, input pixel_in, output ready);
endinterface

@@ rtl/bmo_pix_out_if.sv @@
// filtered pixel channel
interface bmo_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;

  modport source(output valid, output pixel_out, output frame_last, input ready);
  modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

@@ rtl/bmo_cfg_regs.sv @@
// apb register file for frame size and spread mode
module bmo_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmo_pkg::APB_AW-1:0]    paddr,
  input  logic [bmo_pkg::APB_DW-1:0]    pwdata,
  output logic [bmo_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output bmo_pkg::cfg_t                 cfg
);
  import bmo_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_strobe;

  assign reg_idx   = paddr[3:2];
  assign wr_strobe = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= IMG_W_W'(256);
      cfg.image_height <= IMG_H_W'(256);
      cfg.spread_mode  <= MODE_SPREAD_HIGH;
    end else if (wr_strobe) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[IMG_H_W-1:0];
        REG_SPREAD_MODE:  cfg.spread_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg.image_height);
      REG_SPREAD_MODE:  prdata = APB_DW'(cfg.spread_mode);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ rtl/bmo_scan_ctrl.sv @@
// raster position counters, frame setup latch and per-request border flags
module bmo_scan_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmo_pkg::cfg_t                 cfg,
  input  logic                          accept,
  input  logic                          req_type,
  input  logic [7:0]                    pixel_in,
  output logic                          item_go,
  output bmo_pkg::item_t                item,
  output logic [$clog2(MAX_WIDTH)-1:0]  item_col
);
  import bmo_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > IMG_W_W) ? WW : IMG_W_W;

  logic [WW-1:0]      cur_w;
  logic [IMG_H_W-1:0] cur_h;
  logic               cur_mode;
  logic [ROW_W-1:0]   row;
  logic [AW-1:0]      col;

  logic [CW-1:0]      w_ext;
  logic [WW-1:0]      clamp_w;
  logic [IMG_H_W-1:0] clamp_h;
  logic [WW-1:0]      eff_w;
  logic [IMG_H_W-1:0] eff_h;
  logic               eff_mode;
  logic               idle;
  logic               in_frame;
  logic               ignore;
  logic [WW-1:0]      col_inc;
  logic               c_zero;

  assign w_ext = CW'(cfg.image_width);

  always_comb begin
    if (w_ext < CW'(MIN_SIZE)) begin
      clamp_w = WW'(MIN_SIZE);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      clamp_w = WW'(MAX_WIDTH);
    end else begin
      clamp_w = w_ext[WW-1:0];
    end
    if (cfg.image_height < IMG_H_W'(MIN_SIZE)) begin
      clamp_h = IMG_H_W'(MIN_SIZE);
    end else if (cfg.image_height > IMG_H_W'(MAX_HEIGHT)) begin
      clamp_h = IMG_H_W'(MAX_HEIGHT);
    end else begin
      clamp_h = cfg.image_height;
    end
  end

  assign idle     = (row == '0) && (col == '0);
  assign eff_w    = idle ? clamp_w : cur_w;
  assign eff_h    = idle ? clamp_h : cur_h;
  assign eff_mode = idle ? cfg.spread_mode : cur_mode;
  // a pixel past the frame's end counts as flush
  assign in_frame = row < eff_h;
  assign ignore   = (req_type == REQ_FLUSH) && in_frame;
  assign item_go  = accept && !ignore;
  assign col_inc  = WW'(col) + WW'(1);
  assign c_zero   = (col == '0);
  assign item_col = col;

  always_comb begin
    item.has    = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && !c_zero);
    item.last   = (row == ROW_W'(eff_h + IMG_H_W'(1))) && c_zero;
    item.c_zero = c_zero;
    item.c_one  = (col == AW'(1));
    // centre row is row-2 on a column wrap, else row-1
    item.top_ok = c_zero ? (row > ROW_W'(2)) : (row > ROW_W'(1));
    item.bot_ok = c_zero ? (row <= eff_h) : (row < eff_h);
    item.mode   = eff_mode;
    item.pixel  = in_frame ? pixel_in : PIX_LOW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w    <= WW'(256);
      cur_h    <= IMG_H_W'(256);
      cur_mode <= MODE_SPREAD_HIGH;
      row      <= '0;
      col      <= '0;
    end else if (item_go) begin
      if (idle) begin
        cur_w    <= clamp_w;
        cur_h    <= clamp_h;
        cur_mode <= cfg.spread_mode;
      end
      if (item.last) begin
        row <= '0;
        col <= '0;
      end else if (col_inc >= eff_w) begin
        row <= row + ROW_W'(1);
        col <= '0;
      end else begin
        col <= col_inc[AW-1:0];
      end
    end
  end

endmodule

@@ rtl/bmo_line_store.sv @@
// two line memories holding the upper and middle rows of the window
module bmo_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output bmo_pkg::pix_t                 top_q,
  output bmo_pkg::pix_t                 mid_q,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  bmo_pkg::pix_t                 wr_upper,
  input  bmo_pkg::pix_t                 wr_middle
);
  import bmo_pkg::*;

  pix_t upper_line  [MAX_WIDTH];
  pix_t middle_line [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_line[wr_addr]  <= wr_upper;
      middle_line[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      top_q <= upper_line[rd_addr];
      mid_q <= middle_line[rd_addr];
    end
  end

endmodule

@@ rtl/bmo_window.sv @@
// 3x3 window register, spread evaluation and output register
module bmo_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_go,
  input  bmo_pkg::item_t                item,
  input  logic [$clog2(MAX_WIDTH)-1:0]  item_col,
  output logic                          item_ready,
  input  bmo_pkg::pix_t                 top_q,
  input  bmo_pkg::pix_t                 mid_q,
  output logic                          wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  output bmo_pkg::pix_t                 wr_upper,
  output bmo_pkg::pix_t                 wr_middle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bmo_pkg::pix_t                 out_pixel,
  output logic                          out_last
);
  import bmo_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic          s1_valid;
  item_t         s1_item;
  logic [AW-1:0] s1_col;
  win_t          win;
  win_t          win_next;
  win_t          src;
  logic          s1_move;
  pix_t          target;
  logic          hit;
  logic [2:0]    row_en;
  logic [2:0]    col_en;
  pix_t          result;

  assign s1_move    = s1_valid && (!s1_item.has || !out_valid || out_ready);
  assign item_ready = !s1_valid || s1_move;

  assign wr_en     = s1_move;
  assign wr_addr   = s1_col;
  assign wr_upper  = mid_q;
  assign wr_middle = s1_item.pixel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = top_q;
    win_next[1][2] = mid_q;
    win_next[2][2] = s1_item.pixel;
  end

  always_comb begin
    // on a column wrap the centre is the last column still in the old window
    src    = s1_item.c_zero ? win : win_next;
    target = (s1_item.mode == MODE_SPREAD_LOW) ? PIX_LOW : PIX_HIGH;
    row_en = {s1_item.bot_ok, 1'b1, s1_item.top_ok};
    col_en = {2'b11, !s1_item.c_zero && !s1_item.c_one};
    hit    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_en[i] && col_en[j] && (src[i][j] == target)) begin
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      result = target;
    end else if (s1_item.c_zero) begin
      result = src[1][2];
    end else begin
      result = src[1][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_go) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      s1_item <= item;
      s1_col  <= item_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_move) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_item.has) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_item.has) begin
      out_pixel <= result;
      out_last  <= s1_item.last;
    end
  end

endmodule

@@ rtl/binary_morphology_3x3.sv @@
// top level of the streaming 3x3 binary dilation / erosion filter
//
// pixels: raster-order requests, req_type pixel or flush. A frame is image_width x
//   image_height pixels followed by image_width+1 flush requests; flushes outside
//   that drain window are dropped, and a pixel sent after the frame's last pixel
//   counts as a flush.
// filtered: one result per frame pixel in raster order, frame_last on the final one.
//   Results trail the input by one row plus one pixel of requests.
// apb: image_width, image_height, spread_mode at 0x0, 0x4, 0x8; sampled on the first
//   pixel of a frame, so write them between frames.
// pipeline: the request that completes a window passes the line memory read, then the
//   window evaluation into the output register, before its result is valid.
// throughput: one request per cycle unless a held result stalls, set by the single read
//   and write port of each line memory, used once per request.
// reset: counters, window and output valid clear; registers return to 256, 256, 0.
//   The line memories need no clearing, as the border logic masks unwritten entries.
// stall: a held result blocks only requests that make a result; one more request
//   waits in the window stage, then pixels.ready drops until filtered.ready returns.
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmo_pkg::APB_AW-1:0]  paddr,
  input  logic [bmo_pkg::APB_DW-1:0]  pwdata,
  output logic [bmo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  bmo_pix_in_if.sink                  pixels,
  bmo_pix_out_if.source               filtered
);
  import bmo_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  cfg_t          cfg;
  logic          accept;
  logic          item_go;
  item_t         item;
  logic [AW-1:0] item_col;
  logic          item_ready;
  pix_t          top_q;
  pix_t          mid_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pix_t          wr_upper;
  pix_t          wr_middle;

  assign pixels.ready = item_ready;
  assign accept       = pixels.valid && item_ready;

  bmo_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmo_scan_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_scan_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .req_type (pixels.req_type),
    .pixel_in (pixels.pixel_in),
    .item_go  (item_go),
    .item     (item),
    .item_col (item_col)
  );

  bmo_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
    .clk       (clk),
    .rd_en     (item_go),
    .rd_addr   (item_col),
    .top_q     (top_q),
    .mid_q     (mid_q),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle)
  );

  bmo_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk        (clk),
    .rst        (rst),
    .item_go    (item_go),
    .item       (item),
    .item_col   (item_col),
    .item_ready (item_ready),
    .top_q      (top_q),
    .mid_q      (mid_q),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_upper   (wr_upper),
    .wr_middle  (wr_middle),
    .out_valid  (filtered.valid),
    .out_ready  (filtered.ready),
    .out_pixel  (filtered.pixel_out),
    .out_last   (filtered.frame_last)
  );

endmodule
